// File: rtl/ocbm_pkg.sv
// Shared types, constants and controller/datapath interface structs for output-cone marking.
package ocbm_pkg;

	localparam int MAX_WIRES = 4096;
	localparam int WIRE_W    = $clog2(MAX_WIRES);
	localparam int CNT_W     = WIRE_W + 1;
	localparam int OCNT_W    = 7;
	localparam int PROD_W    = OCNT_W + CNT_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RUN  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIRES    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_BITS = 3'd4;

	typedef struct packed {
		logic [1:0]        operation;
		logic [WIRE_W-1:0] wire_index;
		logic [WIRE_W-1:0] left_parent;
		logic [WIRE_W-1:0] right_parent;
		logic              mark_in;
	} item_t;

	typedef struct packed {
		logic              mark_out;
		logic [WIRE_W-1:0] wire_echo;
		logic [CNT_W-1:0]  reached_total;
	} result_t;

	typedef struct packed {
		logic take_item;
		logic load_wr;
		logic out_load;
		logic run_init;
		logic cnt_clr;
		logic cnt_inc;
		logic clr_wr;
		logic cur_start;
		logic cur_fifo;
		logic proc;
		logic sel_right;
		logic chk;
		logic push;
		logic pop;
		logic sw_rd;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       cnt_at_wc;
		logic       cnt_at_starts;
		logic       cand_ok;
		logic       push_ok;
		logic       fifo_empty;
		logic       out_free;
	} sts_t;

endpackage

// File: rtl/ocbm_dpath.sv
// Datapath: configuration, wire tables, flag stores, walk queue, counters and result register.
module ocbm_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ocbm_pkg::item_t                 item,
	input  logic                            result_stall,
	output logic                            result_valid,
	output ocbm_pkg::result_t               result,
	input  logic                            cfg_wr,
	input  logic [ocbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ocbm_pkg::CNT_W-1:0]      cfg_data,
	input  ocbm_pkg::cmd_t                  cmd,
	output ocbm_pkg::sts_t                  sts
);

	localparam int WW = ocbm_pkg::WIRE_W;
	localparam int CW = ocbm_pkg::CNT_W;
	localparam int PW = ocbm_pkg::PROD_W;
	localparam int MW = ocbm_pkg::MAX_WIRES;

	logic [CW-1:0] a_q, b_q, wc_q, ob_q;
	logic [ocbm_pkg::OCNT_W-1:0] oc_q;

	logic [CW-1:0] wcl_q, starts_q, cnt_q, tot_q;
	logic [CW:0]   gb_q;
	logic [CW-1:0] head_q, tail_q;
	logic          out_vld_q;
	ocbm_pkg::result_t out_q;
	ocbm_pkg::item_t   item_q;

	logic [WW-1:0] cur_q, cand_s1, fifo_rd_q, sw_addr_s1;
	logic [2*WW-1:0] pr_q;
	logic mark_rd_q, vis_rd_q, rch_rd_q, sw_vld_s1;

	logic [2*WW-1:0] parent_mem [MW];
	logic            mark_mem   [MW];
	logic            vis_mem    [MW];
	logic            rch_mem    [MW];
	logic [WW-1:0]   fifo_mem   [MW];

	logic [CW-1:0] wc_clip, starts_d, start_wire;
	logic [PW-1:0] prod;
	logic [WW-1:0] cand, mark_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= '0;
			b_q  <= '0;
			wc_q <= CW'(MW);
			oc_q <= ocbm_pkg::OCNT_W'(1);
			ob_q <= CW'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				ocbm_pkg::REG_INPUT_A:  a_q  <= cfg_data;
				ocbm_pkg::REG_INPUT_B:  b_q  <= cfg_data;
				ocbm_pkg::REG_WIRES:    wc_q <= cfg_data;
				ocbm_pkg::REG_OUTPUTS:  oc_q <= cfg_data[ocbm_pkg::OCNT_W-1:0];
				ocbm_pkg::REG_OUT_BITS: ob_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wc_clip  = (wc_q > CW'(MW)) ? CW'(MW) : wc_q;
	assign prod     = PW'(oc_q) * PW'(ob_q);
	assign starts_d = (prod > PW'(wc_clip)) ? wc_clip : prod[CW-1:0];
	assign start_wire = wcl_q - CW'(1) - cnt_q;
	assign cand     = cmd.sel_right ? pr_q[WW-1:0] : pr_q[2*WW-1:WW];
	assign mark_addr = cmd.chk ? cand : item_q.wire_index;

	// Run limits, shared counter, walk pointers and total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcl_q    <= '0;
			starts_q <= '0;
			gb_q     <= '0;
			cnt_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			tot_q    <= '0;
			sw_vld_s1 <= 1'b0;
		end else begin
			if (cmd.run_init) begin
				wcl_q    <= wc_clip;
				starts_q <= starts_d;
				gb_q     <= {1'b0, a_q} + {1'b0, b_q};
				tot_q    <= '0;
			end
			if (cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_inc)
				cnt_q <= cnt_q + CW'(1);
			if (cmd.push)
				tail_q <= tail_q + CW'(1);
			if (cmd.pop)
				head_q <= head_q + CW'(1);
			sw_vld_s1 <= cmd.sw_rd;
			if (sw_vld_s1 && rch_rd_q)
				tot_q <= tot_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item)
			item_q <= item;
		if (cmd.cur_start)
			cur_q <= start_wire[WW-1:0];
		else if (cmd.cur_fifo)
			cur_q <= fifo_rd_q;
		if (cmd.chk)
			cand_s1 <= cand;
		sw_addr_s1 <= cnt_q[WW-1:0];
	end

	// Parent table.
	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			parent_mem[item_q.wire_index] <= {item_q.left_parent, item_q.right_parent};
		if (cmd.proc)
			pr_q <= parent_mem[cur_q];
	end

	// Mark store: written by loads and by the final sweep.
	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			mark_mem[item_q.wire_index] <= item_q.mark_in;
		else if (sw_vld_s1)
			mark_mem[sw_addr_s1] <= ~rch_rd_q;
		mark_rd_q <= mark_mem[mark_addr];
	end

	// Visited flags.
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			vis_mem[cnt_q[WW-1:0]] <= 1'b0;
		else if (cmd.push)
			vis_mem[cand_s1] <= 1'b1;
		vis_rd_q <= vis_mem[cand];
	end

	// Reached flags.
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			rch_mem[cnt_q[WW-1:0]] <= 1'b0;
		else if (cmd.proc)
			rch_mem[cur_q] <= 1'b1;
		if (cmd.sw_rd)
			rch_rd_q <= rch_mem[cnt_q[WW-1:0]];
	end

	// Walk queue.
	always_ff @(posedge clk) begin
		if (cmd.push)
			fifo_mem[tail_q[WW-1:0]] <= cand_s1;
		if (cmd.pop)
			fifo_rd_q <= fifo_mem[head_q[WW-1:0]];
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.out_load)
			out_vld_q <= 1'b1;
		else if (!result_stall)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.mark_out      <= (item_q.operation == ocbm_pkg::OP_READ) ? mark_rd_q : 1'b0;
			out_q.wire_echo     <= (item_q.operation == ocbm_pkg::OP_RUN) ? '0
			                       : item_q.wire_index;
			out_q.reached_total <= tot_q;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	assign sts.op            = item_q.operation;
	assign sts.cnt_at_wc     = (cnt_q == wcl_q);
	assign sts.cnt_at_starts = (cnt_q == starts_q);
	assign sts.cand_ok       = ({1'b0, cand} < wcl_q) && ({2'b0, cand} >= gb_q);
	assign sts.push_ok       = mark_rd_q && !vis_rd_q;
	assign sts.fifo_empty    = (head_q == tail_q);
	assign sts.out_free      = !out_vld_q || !result_stall;

endmodule

// File: rtl/ocbm_ctrl.sv
// Controller state machine that sequences loads, reads and the backward walk.
module ocbm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  ocbm_pkg::sts_t  sts,
	output ocbm_pkg::cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_OP      = 14'b00000000000010,
		S_RDW     = 14'b00000000000100,
		S_CLEAR   = 14'b00000000001000,
		S_KSTART  = 14'b00000000010000,
		S_PROC    = 14'b00000000100000,
		S_LCHK    = 14'b00000001000000,
		S_LPUSH   = 14'b00000010000000,
		S_RCHK    = 14'b00000100000000,
		S_RPUSH   = 14'b00001000000000,
		S_NEXT    = 14'b00010000000000,
		S_FWAIT   = 14'b00100000000000,
		S_SWEEP   = 14'b01000000000000,
		S_DONE    = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   drain_q, drain_d;

	assign item_stall = !((state_q == S_IDLE) && sts.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			drain_q <= drain_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		drain_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid && sts.out_free) begin
					cmd.take_item = 1'b1;
					state_d = S_OP;
				end
			end
			S_OP: begin
				unique case (sts.op)
					ocbm_pkg::OP_LOAD: begin
						cmd.load_wr  = 1'b1;
						cmd.out_load = 1'b1;
						state_d = S_IDLE;
					end
					ocbm_pkg::OP_READ: state_d = S_RDW;
					ocbm_pkg::OP_RUN: begin
						cmd.run_init = 1'b1;
						cmd.cnt_clr  = 1'b1;
						state_d = S_CLEAR;
					end
					default: begin
						cmd.out_load = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_RDW: begin
				cmd.out_load = 1'b1;
				state_d = S_IDLE;
			end
			S_CLEAR: begin
				if (sts.cnt_at_wc) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_KSTART;
				end else begin
					cmd.clr_wr  = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_KSTART: begin
				if (sts.cnt_at_starts) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_SWEEP;
				end else begin
					cmd.cur_start = 1'b1;
					state_d = S_PROC;
				end
			end
			S_PROC: begin
				cmd.proc = 1'b1;
				state_d = S_LCHK;
			end
			S_LCHK: begin
				if (sts.cand_ok) begin
					cmd.chk = 1'b1;
					state_d = S_LPUSH;
				end else begin
					state_d = S_RCHK;
				end
			end
			S_LPUSH: begin
				cmd.push = sts.push_ok;
				state_d = S_RCHK;
			end
			S_RCHK: begin
				cmd.sel_right = 1'b1;
				if (sts.cand_ok) begin
					cmd.chk = 1'b1;
					state_d = S_RPUSH;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_RPUSH: begin
				cmd.push = sts.push_ok;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				if (!sts.fifo_empty) begin
					cmd.pop = 1'b1;
					state_d = S_FWAIT;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d = S_KSTART;
				end
			end
			S_FWAIT: begin
				cmd.cur_fifo = 1'b1;
				state_d = S_PROC;
			end
			S_SWEEP: begin
				// Holding in the sweep state after the last read lets the final mark write land.
				if (sts.cnt_at_wc) begin
					drain_d = 1'b1;
					if (drain_q)
						state_d = S_DONE;
				end else begin
					cmd.sw_rd   = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_DONE: begin
				cmd.out_load = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/output_cone_backward_marking.sv
// Top level of the output-cone backward marking engine.
// A load or an unused operation code loads the result register in the operation state; a read
// does so from a separate read state. A run clears the flags of all W wires (W the clipped wire
// count), walks back from each of the S start wires, checking both parents of each wire against
// the gate range and queueing marked unvisited ones, then sweeps the marks. One item at a time;
// a new one waits for a free result register. Reset clears the controller, pointers and counters.
module output_cone_backward_marking (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  ocbm_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output ocbm_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ocbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ocbm_pkg::CNT_W-1:0]      cfg_data
);

	ocbm_pkg::cmd_t cmd;
	ocbm_pkg::sts_t sts;

	// Configuration beats are always taken; the user must write only while the block is idle, as
	// it does not check. Reset returns the configuration to defaults; the wire tables start unknown.
	assign cfg_ready = 1'b1;

	// The controller sequences each operation and the walk; the datapath owns all storage.
	ocbm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	ocbm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// File: tb/tb_output_cone_backward_marking.sv
// Self-checking testbench for the output-cone backward marking engine.
module tb_output_cone_backward_marking;

	// Operation code 3 is unused by the block but is still part of the stimulus.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         N_PHASES  = 6;

	logic                           clk;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_stall;
	ocbm_pkg::item_t                item;
	logic                           result_valid;
	logic                           result_stall;
	ocbm_pkg::result_t              result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [ocbm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ocbm_pkg::CNT_W-1:0]     cfg_data;

	output_cone_backward_marking i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Shadow copy of the wire table and the configuration. The definition flags
	// record which entries hold known contents, so that the stimulus never
	// makes the block read an entry that was never written.
	logic [ocbm_pkg::WIRE_W-1:0] shadow_left [ocbm_pkg::MAX_WIRES];
	logic [ocbm_pkg::WIRE_W-1:0] shadow_right[ocbm_pkg::MAX_WIRES];
	bit                shadow_mark [ocbm_pkg::MAX_WIRES];
	bit                parents_known[ocbm_pkg::MAX_WIRES];
	bit                mark_known  [ocbm_pkg::MAX_WIRES];
	bit                visited     [ocbm_pkg::MAX_WIRES];
	bit                reached     [ocbm_pkg::MAX_WIRES];
	int                walk_queue  [ocbm_pkg::MAX_WIRES + 1];
	int                gate_a_cnt, gate_b_cnt, wires_cfg, outputs_cfg, out_bits_cfg;
	int                reached_cnt;

	// Results still owed by the block, oldest first.
	ocbm_pkg::result_t pending_results[$];
	int                mismatches;
	int                n_loads, n_runs, n_reads, n_unused, n_results, max_reached;
	bit                quiet;

	// One row of the directed table. Rows with a typed answer are checked
	// against it; the rest are checked against the predictor.
	typedef struct {
		ocbm_pkg::item_t   beat;
		bit                typed;
		ocbm_pkg::result_t answer;
	} directed_row_t;

	directed_row_t directed[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Walks the output cone the way the block does. With apply clear it only
	// tells whether every entry the walk touches is known; with apply set it
	// also rewrites the marks and the reached count.
	function automatic bit walk_cone(input bit apply);
		int wc, starts, gate_base, head, tail, cur, par, count;
		bit all_known;
		wc = (wires_cfg > ocbm_pkg::MAX_WIRES) ? ocbm_pkg::MAX_WIRES : wires_cfg;
		starts = outputs_cfg * out_bits_cfg;
		if (starts > wc)
			starts = wc;
		gate_base = gate_a_cnt + gate_b_cnt;
		all_known = 1'b1;
		foreach (visited[w]) begin
			visited[w] = 1'b0;
			reached[w] = 1'b0;
		end
		for (int k = 0; k < starts; k++) begin
			head = 0;
			tail = 0;
			walk_queue[tail++] = wc - 1 - k;
			while (head < tail) begin
				cur = walk_queue[head++];
				reached[cur] = 1'b1;
				if (!parents_known[cur])
					all_known = 1'b0;
				for (int p = 0; p < 2; p++) begin
					par = p ? shadow_right[cur] : shadow_left[cur];
					// Only marked, unvisited gate wires inside the circuit are followed.
					if (par < wc && par >= gate_base) begin
						if (!mark_known[par])
							all_known = 1'b0;
						if (shadow_mark[par] && !visited[par]) begin
							visited[par] = 1'b1;
							walk_queue[tail++] = par;
						end
					end
				end
			end
		end
		if (apply) begin
			count = 0;
			for (int w = 0; w < wc; w++) begin
				shadow_mark[w] = !reached[w];
				mark_known[w] = 1'b1;
				if (reached[w])
					count++;
			end
			reached_cnt = count;
		end
		return all_known;
	endfunction

	// Applies one accepted beat to the shadow state and returns its answer.
	function automatic ocbm_pkg::result_t predict_marking(input ocbm_pkg::item_t b);
		ocbm_pkg::result_t r;
		r.mark_out = 1'b0;
		r.wire_echo = b.wire_index;
		case (b.operation)
			ocbm_pkg::OP_LOAD: begin
				shadow_left[b.wire_index] = b.left_parent;
				shadow_right[b.wire_index] = b.right_parent;
				shadow_mark[b.wire_index] = b.mark_in;
				parents_known[b.wire_index] = 1'b1;
				mark_known[b.wire_index] = 1'b1;
				n_loads++;
			end
			ocbm_pkg::OP_RUN: begin
				void'(walk_cone(1'b1));
				r.wire_echo = '0;
				n_runs++;
				if (reached_cnt > max_reached)
					max_reached = reached_cnt;
			end
			ocbm_pkg::OP_READ: begin
				r.mark_out = shadow_mark[b.wire_index];
				n_reads++;
			end
			default: n_unused++;
		endcase
		r.reached_total = reached_cnt[ocbm_pkg::CNT_W-1:0];
		return r;
	endfunction

	// Offers one beat after a random gap and returns once it is accepted.
	// Valid stays high across back-to-back beats.
	task automatic send_beat(input ocbm_pkg::item_t b, input bit typed,
		input ocbm_pkg::result_t answer);
		int gap;
		ocbm_pkg::result_t predicted;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = predict_marking(b);
		pending_results = {pending_results, (typed ? answer : predicted)};
	endtask

	task automatic write_register(input logic [ocbm_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[ocbm_pkg::CNT_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			ocbm_pkg::REG_INPUT_A:  gate_a_cnt = value;
			ocbm_pkg::REG_INPUT_B:  gate_b_cnt = value;
			ocbm_pkg::REG_WIRES:    wires_cfg = value;
			ocbm_pkg::REG_OUTPUTS:  outputs_cfg = value;
			ocbm_pkg::REG_OUT_BITS: out_bits_cfg = value;
			default: ;
		endcase
	endtask

	// Waits until the block has answered everything.
	task automatic drain_results;
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Builds one random beat that never makes the block touch an unwritten entry.
	function automatic ocbm_pkg::item_t random_beat();
		ocbm_pkg::item_t b;
		int roll, wc, top, start;
		wc = (wires_cfg > ocbm_pkg::MAX_WIRES) ? ocbm_pkg::MAX_WIRES : wires_cfg;
		top = (wc + 3 > ocbm_pkg::MAX_WIRES - 1) ? ocbm_pkg::MAX_WIRES - 1 : wc + 3;
		b.operation = ocbm_pkg::OP_LOAD;
		b.wire_index = ocbm_pkg::WIRE_W'(($urandom_range(0, 9) == 0) ? $urandom
			: $urandom_range(0, wc - 1));
		b.left_parent = ocbm_pkg::WIRE_W'(($urandom_range(0, 4) == 0) ? $urandom
			: $urandom_range(0, top));
		b.right_parent = ocbm_pkg::WIRE_W'(($urandom_range(0, 4) == 0) ? $urandom
			: $urandom_range(0, top));
		b.mark_in = 1'($urandom);
		roll = $urandom_range(0, 99);
		if (roll >= 45 && roll < 75) begin
			// Read a known mark, searching forward from a random wire.
			start = $urandom_range(0, ocbm_pkg::MAX_WIRES - 1);
			for (int n = 0; n < ocbm_pkg::MAX_WIRES; n++)
				if (mark_known[(start + n) % ocbm_pkg::MAX_WIRES]) begin
					b.operation = ocbm_pkg::OP_READ;
					b.wire_index = ocbm_pkg::WIRE_W'((start + n) % ocbm_pkg::MAX_WIRES);
					break;
				end
		end else if (roll >= 75 && roll < 93) begin
			// A run goes out only when the walk stays on written entries;
			// otherwise fill in the lowest unwritten wire of the circuit.
			if (walk_cone(1'b0))
				b.operation = ocbm_pkg::OP_RUN;
			else
				for (int w = 0; w < wc; w++)
					if (!parents_known[w]) begin
						b.wire_index = ocbm_pkg::WIRE_W'(w);
						break;
					end
		end else if (roll >= 93) begin
			b.operation = OP_UNUSED;
		end
		return b;
	endfunction

	// Result side: checks each accepted beat and draws its own stall pattern.
	// After the 400th result it holds off for a long stretch so that the
	// block backs up and stalls the sender.
	initial begin
		int hold;
		ocbm_pkg::result_t want;
		hold = 0;
		result_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				n_results++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, wire_echo", result.wire_echo, -1);
				end else begin
					want = pending_results.pop_front();
					if (result.mark_out !== want.mark_out)
						report_mismatch("mark_out", result.mark_out, want.mark_out);
					if (result.wire_echo !== want.wire_echo)
						report_mismatch("wire_echo", result.wire_echo, want.wire_echo);
					if (result.reached_total !== want.reached_total)
						report_mismatch("reached_total", result.reached_total,
							want.reached_total);
				end
				hold = quiet ? 0 : $urandom_range(0, 9);
				if (n_results == 400)
					hold = 300;
			end
			if (!arst_n) begin
				result_stall <= 1'b1;
			end else if (hold > 0) begin
				result_stall <= 1'b1;
				hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#30000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int phase_cfg[N_PHASES][5];
		ocbm_pkg::result_t none;
		directed_row_t row;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		mismatches = 0;
		n_loads = 0;
		n_runs = 0;
		n_reads = 0;
		n_unused = 0;
		n_results = 0;
		max_reached = 0;
		gate_a_cnt = 0;
		gate_b_cnt = 0;
		wires_cfg = ocbm_pkg::MAX_WIRES;
		outputs_cfg = 1;
		out_bits_cfg = 1;
		reached_cnt = 0;
		none = '0;
		foreach (shadow_mark[w]) begin
			shadow_left[w] = '0;
			shadow_right[w] = '0;
			shadow_mark[w] = 1'b0;
			parents_known[w] = 1'b0;
			mark_known[w] = 1'b0;
		end

		// Directed part, run on the reset configuration: the whole 4096-wire
		// circuit with wire 4095 as the only start. The walk loops back into
		// the start wire, and wire 0 names itself as its own parent.
		row.typed = 1'b1;
		row.beat = '{ocbm_pkg::OP_LOAD, 12'd4095, 12'd4094, 12'd0, 1'b1};
		row.answer = '{1'b0, 12'd4095, 13'd0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_LOAD, 12'd4094, 12'd4095, 12'd4095, 1'b1};
		row.answer = '{1'b0, 12'd4094, 13'd0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_LOAD, 12'd0, 12'd0, 12'd0, 1'b1};
		row.answer = '{1'b0, 12'd0, 13'd0};
		directed = {directed, row};
		row.beat = '{OP_UNUSED, 12'd4095, 12'd4095, 12'd4095, 1'b1};
		row.answer = '{1'b0, 12'd4095, 13'd0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_READ, 12'd4095, 12'd0, 12'd0, 1'b0};
		row.answer = '{1'b1, 12'd4095, 13'd0};
		directed = {directed, row};
		row.typed = 1'b0;
		row.answer = none;
		row.beat = '{ocbm_pkg::OP_RUN, 12'd0, 12'd0, 12'd0, 1'b0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_READ, 12'd4095, 12'd0, 12'd0, 1'b0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_READ, 12'd4094, 12'd0, 12'd0, 1'b0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 1'b0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_READ, 12'd1, 12'd0, 12'd0, 1'b0};
		directed = {directed, row};
		// With the reached wires now unmarked, a second run stops at the start.
		row.beat = '{ocbm_pkg::OP_RUN, 12'd0, 12'd0, 12'd0, 1'b0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_LOAD, 12'd2048, 12'd4095, 12'd0, 1'b0};
		directed = {directed, row};
		row.beat = '{ocbm_pkg::OP_READ, 12'd2048, 12'd0, 12'd0, 1'b0};
		directed = {directed, row};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_beat(directed[i].beat, directed[i].typed, directed[i].answer);
		drain_results();

		// Each phase: input_a, input_b, wire count, outputs, bits per output.
		// Among them: a one-wire circuit with large input and start counts, every
		// wire a start, and the full-size circuit.
		phase_cfg[0] = '{0, 0, 16, 1, 1};
		phase_cfg[1] = '{4, 3, 40, 3, 5};
		phase_cfg[2] = '{4096, 4096, 1, 64, 4096};
		phase_cfg[3] = '{2, 1, 64, 2, 4};
		phase_cfg[4] = '{0, 5, 24, 64, 4096};
		phase_cfg[5] = '{4000, 94, 4096, 1, 2};
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_register(ocbm_pkg::REG_INPUT_A, phase_cfg[ph][0]);
			write_register(ocbm_pkg::REG_INPUT_B, phase_cfg[ph][1]);
			write_register(ocbm_pkg::REG_WIRES, phase_cfg[ph][2]);
			write_register(ocbm_pkg::REG_OUTPUTS, phase_cfg[ph][3]);
			write_register(ocbm_pkg::REG_OUT_BITS, phase_cfg[ph][4]);
			// One phase runs with no idling on either side.
			quiet = (ph == 3);
			repeat (155)
				send_beat(random_beat(), 1'b0, none);
			drain_results();
		end
		quiet = 1'b0;

		$display("Covered %0d loads, %0d runs, %0d reads and %0d unused-code beats",
			n_loads, n_runs, n_reads, n_unused);
		$display("over %0d configurations; largest cone reached %0d wires.",
			N_PHASES + 1, max_reached);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
